// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the checker module bsfe_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// bsfe_pkg
// Types, constants and command/status bundles of the frame extractor.
// ----------------------------------------------------------------------------
package bsfe_pkg;

  localparam int CHANNELS      = 2;
  localparam int BUFFER_DEPTH  = 64;
  localparam int HEADER_SIZE   = 4;
  localparam int TRAILER_SIZE  = 1;
  localparam int LENGTH_OFFSET = 1;

  localparam int MIN_LEN = HEADER_SIZE + TRAILER_SIZE;
  localparam int POS_W   = $clog2(BUFFER_DEPTH);
  localparam int CNT_W   = $clog2(BUFFER_DEPTH + 1);
  localparam int CH_W    = 1;
  localparam int ADDR_W  = $clog2(CHANNELS * BUFFER_DEPTH);
  localparam int LEN_W   = 7;

  typedef enum logic [1:0] {
    REG_HEAD_SIGN     = 2'd0,
    REG_TAIL_SIGN     = 2'd1,
    REG_MAX_FRAME_LEN = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_CHK,
    ST_HEAD,
    ST_LEN0,
    ST_LEN1,
    ST_TAILRD,
    ST_TAIL,
    ST_EMRD,
    ST_EMLD,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    RD_OFF,
    RD_LEN0,
    RD_LEN1,
    RD_TAIL,
    RD_EMIT
  } rd_sel_t;

  typedef struct packed {
    logic    append;
    logic    scan_init;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    drop;
    logic    latch_lo;
    logic    latch_len;
    logic    emit_start;
    logic    emit_load;
    logic    emit_adv;
    logic    frame_adv;
    logic    commit;
  } cmd_t;

  typedef struct packed {
    logic remain_low;
    logic head_match;
    logic len_ok;
    logic len_short;
    logic tail_match;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

// ===== rtl/core/bsfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsfe_ctrl
// Sequencer for append, buffer scan and frame emission.
// ----------------------------------------------------------------------------
module bsfe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tlast,
  input  logic [0:0]       s_tuser,
  output logic             s_tready,
  input  bsfe_pkg::status_t sts,
  output bsfe_pkg::cmd_t    cmd
);
  import bsfe_pkg::*;

  state_t state;
  state_t state_next;
  logic   ch_ok;

  assign ch_ok = (int'(s_tuser) < CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_OFF;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && ch_ok) begin
          cmd.append = 1'b1;
          if (s_tlast) begin
            state_next = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = ST_CHK;
      end
      ST_CHK: begin
        if (sts.remain_low) begin
          state_next = ST_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_OFF;
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (sts.head_match) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEN0;
          state_next = ST_LEN0;
        end else begin
          cmd.drop   = 1'b1;
          state_next = ST_CHK;
        end
      end
      ST_LEN0: begin
        cmd.latch_lo = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_LEN1;
        state_next   = ST_LEN1;
      end
      ST_LEN1: begin
        if (!sts.len_ok) begin
          cmd.drop   = 1'b1;
          state_next = ST_CHK;
        end else if (sts.len_short) begin
          state_next = ST_DONE;
        end else begin
          cmd.latch_len = 1'b1;
          state_next    = ST_TAILRD;
        end
      end
      ST_TAILRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_TAIL;
        state_next = ST_TAIL;
      end
      ST_TAIL: begin
        if (sts.tail_match) begin
          cmd.emit_start = 1'b1;
          state_next     = ST_EMRD;
        end else begin
          cmd.drop   = 1'b1;
          state_next = ST_CHK;
        end
      end
      ST_EMRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_EMIT;
        state_next = ST_EMLD;
      end
      ST_EMLD: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) begin
            cmd.frame_adv = 1'b1;
            state_next    = ST_CHK;
          end else begin
            cmd.emit_adv = 1'b1;
            state_next   = ST_EMRD;
          end
        end
      end
      ST_DONE: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bsfe_dpath.sv =====
// ----------------------------------------------------------------------------
// bsfe_dpath
// Channel ring buffers, scan counters, config registers and output register.
// ----------------------------------------------------------------------------
module bsfe_dpath (
  input  logic              clk,
  input  logic              rst,
  input  bsfe_pkg::cmd_t     cmd,
  output bsfe_pkg::status_t  sts,
  input  logic [7:0]        s_tdata,
  input  logic [0:0]        s_tuser,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic [0:0]        m_tuser,
  output logic              m_tlast
);
  import bsfe_pkg::*;

  logic [7:0]         mem [CHANNELS * BUFFER_DEPTH];
  logic [POS_W-1:0]   hd [CHANNELS];
  logic [CNT_W-1:0]   fill [CHANNELS];

  logic [7:0]         head_sign;
  logic [7:0]         tail_sign;
  logic [LEN_W-1:0]   max_frame_len;

  logic [CH_W-1:0]    ch;
  logic [CNT_W-1:0]   off;
  logic [CNT_W-1:0]   remain;
  logic [LEN_W-1:0]   len;
  logic [CNT_W-1:0]   idx;
  logic [7:0]         len_lo;
  logic [7:0]         rdata;

  logic [CNT_W-1:0]   rd_pos;
  logic [POS_W-1:0]   rd_ring;
  logic [ADDR_W-1:0]  rd_addr;
  logic [POS_W-1:0]   wr_ring;
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_room;
  logic [15:0]        len_full;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_OFF:  rd_pos = off;
      RD_LEN0: rd_pos = off + CNT_W'(LENGTH_OFFSET);
      RD_LEN1: rd_pos = off + CNT_W'(LENGTH_OFFSET + 1);
      RD_TAIL: rd_pos = off + CNT_W'(len) - CNT_W'(1);
      RD_EMIT: rd_pos = off + idx;
      default: rd_pos = off;
    endcase
  end

  assign rd_ring = hd[ch] + rd_pos[POS_W-1:0];
  assign rd_addr = {ch, rd_ring};
  assign wr_ring = hd[s_tuser] + fill[s_tuser][POS_W-1:0];
  assign wr_addr = {s_tuser, wr_ring};
  assign wr_room = (fill[s_tuser] < CNT_W'(BUFFER_DEPTH));
  assign len_full = {rdata, len_lo};

  always_comb begin
    sts.remain_low = (remain < CNT_W'(MIN_LEN));
    sts.head_match = (rdata == head_sign);
    sts.len_ok     = (len_full >= 16'(MIN_LEN)) && (len_full <= 16'(max_frame_len));
    sts.len_short  = (remain < CNT_W'(len_full[LEN_W-1:0]));
    sts.tail_match = (rdata == tail_sign);
    sts.out_free   = !m_tvalid || m_tready;
    sts.emit_last  = ((idx + CNT_W'(1)) == CNT_W'(len));
  end

  always_ff @(posedge clk) begin
    if (cmd.append && wr_room) begin
      mem[wr_addr] <= s_tdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        hd[c]   <= '0;
        fill[c] <= '0;
      end
      head_sign     <= '0;
      tail_sign     <= '0;
      max_frame_len <= LEN_W'(64);
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_HEAD_SIGN:     head_sign     <= cfg_data;
          REG_TAIL_SIGN:     tail_sign     <= cfg_data;
          REG_MAX_FRAME_LEN: max_frame_len <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.append && wr_room) begin
        fill[s_tuser] <= fill[s_tuser] + CNT_W'(1);
      end
      if (cmd.commit) begin
        hd[ch]   <= hd[ch] + off[POS_W-1:0];
        fill[ch] <= remain;
      end
      if (cmd.emit_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      ch <= s_tuser;
    end
    if (cmd.scan_init) begin
      off    <= '0;
      remain <= fill[ch];
    end else if (cmd.drop) begin
      off    <= off + CNT_W'(1);
      remain <= remain - CNT_W'(1);
    end else if (cmd.frame_adv) begin
      off    <= off + CNT_W'(len);
      remain <= remain - CNT_W'(len);
    end
    if (cmd.latch_lo) begin
      len_lo <= rdata;
    end
    if (cmd.latch_len) begin
      len <= len_full[LEN_W-1:0];
    end
    if (cmd.emit_start) begin
      idx <= '0;
    end else if (cmd.emit_adv) begin
      idx <= idx + CNT_W'(1);
    end
    if (cmd.emit_load) begin
      m_tdata <= rdata;
      m_tuser <= ch;
      m_tlast <= sts.emit_last;
    end
  end

endmodule

// ===== rtl/core/byte_stream_frame_extractor_unit.sv =====
// An item without chunk end is taken while s_tready is high; s_tready stays high for the next.
// A chunk end starts a scan of that channel's ring buffer: a byte failing the head check or a
// candidate's head byte with a bad length or tail is dropped, a full frame is sent byte by byte
// as the output frees, and a partial frame ends the scan. No input is taken during a scan; the
// buffer memory has a single read port. Reset (rst, synchronous, active high) empties all
// channel buffers, clears the output valid flag and sets head_sign 0, tail_sign 0, max_frame_len 64.
// ----------------------------------------------------------------------------
// byte_stream_frame_extractor_unit
// Length-prefixed frame extractor with shared head and tail sign bytes, one ring buffer per channel.
// ----------------------------------------------------------------------------
module byte_stream_frame_extractor_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] rx_byte
  input  logic [0:0] s_tuser,    // [0] rx_channel
  input  logic       s_tlast,    // chunk_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] frame_byte
  output logic [0:0] m_tuser,    // [0] frame_channel
  output logic       m_tlast,    // frame_last
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import bsfe_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  bsfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsfe_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== rtl/core/bsfe_checker.sv =====
// ----------------------------------------------------------------------------
// bsfe_checker
// Port-level checks of the frame extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic [0:0] s_tuser,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [0:0] m_tuser,
  input logic       m_tlast,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [1:0] cfg_index,
  input logic [7:0] cfg_data
);

  `ASSERT_CLK(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable({m_tdata, m_tuser, m_tlast})), "output item changed while stalled")
  `ASSERT_CLK(a_scan_blocks, clk, rst, (s_tvalid && s_tready && s_tlast) |=> !s_tready, "input taken right after a chunk end")
  `ASSERT_CLK(a_plain_keeps, clk, rst, (s_tvalid && s_tready && !s_tlast) |=> s_tready, "input stalled after a plain item")
  `ASSERT_ALWAYS(a_reset_state, clk, rst |=> (!m_tvalid && s_tready), "not idle after reset")

endmodule

bind byte_stream_frame_extractor_unit bsfe_checker u_bsfe_checker (.*);
